@@ hw/rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Opcodes, status codes and field widths of the double-ended byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int unsigned OpW    = 2;
    localparam int unsigned DataW  = 8;
    localparam int unsigned StatW  = 2;
    localparam int unsigned FillW  = 5;

    typedef enum logic [OpW-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/char_deque_buffer_core.sv @@
// ----------------------------------------------------------------------------
// char_deque_buffer_core
// Double-ended byte queue in a circular buffer of DEPTH entries. Each item
// pushes a byte at the back or front, or pops one from the front or back,
// and yields one result with the popped byte, a status (underflow on an
// empty pop, overflow on a full push, which is dropped), the empty flag and
// the fill count (low 5 bits). One item is taken per cycle unless the input
// stalls. The byte store is read at the accepting edge; its registered read
// data moves into the output register when that register is free or being
// drained. The input stalls only when both stages hold an item and the
// output is stalled. Head and count live in registers and are updated at
// acceptance, so a pop right after a push sees the pushed byte. The byte
// store has no reset; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module char_deque_buffer_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_data_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_data_out,
    output logic [1:0]      o_status,
    output logic            o_is_empty,
    output logic [4:0]      o_fill_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // pointer state
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    // stage one: read data arrives from the store
    logic                  r_s1_valid;
    logic                  r_s1_pop;
    cdq_pkg::t_status      r_s1_status;
    logic                  r_s1_empty;
    logic [CW-1:0]         r_s1_count;

    // output register
    logic                  r_out_valid;
    logic [cdq_pkg::DataW-1:0] r_out_data;
    cdq_pkg::t_status      r_out_status;
    logic                  r_out_empty;
    logic [cdq_pkg::FillW-1:0] r_out_count;

    logic                  accept;
    logic                  s1_move;
    cdq_pkg::t_op          op;
    cdq_pkg::t_status      n_status;
    logic                  full;
    logic                  empty;
    logic [AW:0]           sum;
    logic [AW:0]           sum_m1;
    logic [AW-1:0]         back_free;
    logic [AW-1:0]         back_used;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [cdq_pkg::DataW-1:0] rd_data;

    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;
    assign op         = cdq_pkg::t_op'(i_opcode);

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // index arithmetic, all sums stay below twice the depth
    assign sum       = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign sum_m1    = sum - (AW+1)'(1);
    assign back_free = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : sum[AW-1:0];
    assign back_used = (sum_m1 >= (AW+1)'(DEPTH)) ? AW'(sum_m1 - (AW+1)'(DEPTH))
                                                   : sum_m1[AW-1:0];
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = cdq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = back_free;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        unique case (op)
            cdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = accept;
                    wr_addr = back_free;
                    n_count = r_count + CW'(1);
                end
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = accept;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    rd_en   = accept;
                    rd_addr = r_head;
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    rd_en   = accept;
                    rd_addr = back_used;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = cdq_pkg::ST_OK;
            end
        endcase
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DataW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop    <= rd_en;
            r_s1_status <= n_status;
            r_s1_empty  <= (n_count == '0);
            r_s1_count  <= n_count;
        end
        if (s1_move && r_s1_valid) begin
            r_out_data   <= r_s1_pop ? rd_data : '0;
            r_out_status <= r_s1_status;
            r_out_empty  <= r_s1_empty;
            r_out_count  <= cdq_pkg::FillW'(r_s1_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_status     = r_out_status;
    assign o_is_empty   = r_out_empty;
    assign o_fill_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above depth");

    a_underflow_keeps_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && empty && (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_BACK))
        |=> (r_count == '0))
        else $error("underflowing pop changed count");

    a_overflow_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (op == cdq_pkg::OP_PUSH_BACK || op == cdq_pkg::OP_PUSH_FRONT))
        |=> (r_count == CW'(DEPTH)) && (r_head == $past(r_head)))
        else $error("full push changed state");

    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with free pipeline");

    a_underflow_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == cdq_pkg::ST_UNDERFLOW)
        |-> (r_out_data == '0))
        else $error("underflow result carries data");

endmodule

`default_nettype wire

@@ tb/tb_char_deque_buffer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_deque_buffer_core
// Self-checking bench for the double-ended byte queue. A driver offers items
// from a queue of pending operations. A shadow deque predicts the result of
// each accepted item. A monitor checks every result against the oldest
// prediction. A directed opening covers underflow, overflow and both ends.
// Random bursts with a push or pop bias then run the queue between empty and
// full. The phases vary sender gaps and receiver stalls, and one long output
// hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------
module tb_char_deque_buffer_core;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned HOLD_LEN   = 48;
    localparam int unsigned RAND_ITEMS = 205;

    typedef struct packed {
        cdq_pkg::t_op              op;
        logic [cdq_pkg::DataW-1:0] data;
    } t_item;

    typedef struct packed {
        logic [cdq_pkg::DataW-1:0] data;
        cdq_pkg::t_status          status;
        logic                      empty;
        logic [cdq_pkg::FillW-1:0] fill;
    } t_result;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      in_valid = 1'b0;
    logic [cdq_pkg::OpW-1:0]   opcode   = '0;
    logic [cdq_pkg::DataW-1:0] data_in  = '0;
    logic                      out_stall = 1'b0;

    logic                      in_stall;
    logic                      out_valid;
    logic [cdq_pkg::DataW-1:0] data_out;
    logic [cdq_pkg::StatW-1:0] status;
    logic                      is_empty;
    logic [cdq_pkg::FillW-1:0] fill_count;

    t_item   op_queue[$];
    t_result result_q[$];
    t_item   cur_item;

    logic [cdq_pkg::DataW-1:0] shadow_bytes [DEPTH];
    int unsigned      shadow_head  = 0;
    int unsigned      shadow_count = 0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_start     = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned errors         = 0;

    char_deque_buffer_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_opcode    (opcode),
        .i_data_in   (data_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_data_out  (data_out),
        .o_status    (status),
        .o_is_empty  (is_empty),
        .o_fill_count(fill_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result deque_apply(t_item it);
        t_result r;
        r.data   = '0;
        r.status = cdq_pkg::ST_OK;
        case (it.op) inside
            cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = cdq_pkg::ST_OVERFLOW;
                end else if (it.op == cdq_pkg::OP_PUSH_BACK) begin
                    shadow_bytes[(shadow_head + shadow_count) % DEPTH] = it.data;
                    shadow_count++;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_bytes[shadow_head] = it.data;
                    shadow_count++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = cdq_pkg::ST_UNDERFLOW;
                end else if (it.op == cdq_pkg::OP_POP_FRONT) begin
                    r.data = shadow_bytes[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end else begin
                    r.data = shadow_bytes[(shadow_head + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            end
        endcase
        r.empty = (shadow_count == 0);
        r.fill  = cdq_pkg::FillW'(shadow_count);
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                result_q.insert(result_q.size(), deque_apply(cur_item));
            end
            if (!in_valid || !in_stall) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = op_queue[0];
                    op_queue.delete(0);
                    opcode   <= cur_item.op;
                    data_in  <= cur_item.data;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result with no item pending");
                    errors++;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (data_out !== want.data) begin
                        $error("data_out: expected %0h, got %0h", want.data, data_out);
                        errors++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (is_empty !== want.empty) begin
                        $error("is_empty: expected %0b, got %0b", want.empty, is_empty);
                        errors++;
                    end
                    if (fill_count !== want.fill) begin
                        $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void queue_item(cdq_pkg::t_op op, logic [cdq_pkg::DataW-1:0] data);
        t_item it;
        it.op   = op;
        it.data = data;
        op_queue.insert(op_queue.size(), it);
    endfunction

    // bursts biased to push or to pop, now and then unbiased, so the queue swings between empty and full
    task automatic add_random(input int unsigned count);
        int unsigned  left;
        int unsigned  burst;
        int unsigned  push_pct;
        cdq_pkg::t_op op;
        left = count;
        while (left != 0) begin
            burst = $urandom_range(4, 40);
            if (burst > left) begin
                burst = left;
            end
            push_pct = ($urandom_range(0, 1) != 0) ? 80 : 20;
            if ($urandom_range(0, 9) == 0) begin
                push_pct = 50;
            end
            repeat (burst) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    op = ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_PUSH_BACK
                                                     : cdq_pkg::OP_PUSH_FRONT;
                end else begin
                    op = ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_POP_FRONT
                                                     : cdq_pkg::OP_POP_BACK;
                end
                queue_item(op, cdq_pkg::DataW'($urandom_range(0, 255)));
            end
            left -= burst;
        end
    endtask

    task automatic wait_idle;
        while (op_queue.size() != 0 || in_valid || result_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // underflow at both ends, then push and pop at both ends
        queue_item(cdq_pkg::OP_POP_FRONT, 8'h00);
        queue_item(cdq_pkg::OP_POP_BACK, 8'hFF);
        queue_item(cdq_pkg::OP_PUSH_BACK, 8'h00);
        queue_item(cdq_pkg::OP_PUSH_FRONT, 8'hFF);
        queue_item(cdq_pkg::OP_POP_FRONT, 8'h00);
        queue_item(cdq_pkg::OP_POP_BACK, 8'h00);
        // fill from both ends, then overflow at both ends and pop from the back
        for (n = 0; n < DEPTH; n++) begin
            queue_item((n % 2 != 0) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK,
                       cdq_pkg::DataW'(8'h5A ^ (n * 17)));
        end
        queue_item(cdq_pkg::OP_PUSH_BACK, 8'hAA);
        queue_item(cdq_pkg::OP_PUSH_FRONT, 8'h55);
        queue_item(cdq_pkg::OP_POP_BACK, 8'h00);

        // no idling, with one long output hold-off
        add_random(RAND_ITEMS + 40);
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        wait_idle();

        @(posedge i_clk);
        send_idle_pct  <= 65;
        recv_stall_pct <= 0;
        add_random(RAND_ITEMS);
        wait_idle();

        @(posedge i_clk);
        send_idle_pct  <= 0;
        recv_stall_pct <= 65;
        add_random(RAND_ITEMS);
        wait_idle();

        @(posedge i_clk);
        send_idle_pct  <= 34;
        recv_stall_pct <= 34;
        add_random(RAND_ITEMS);

        n = 0;
        while ((op_queue.size() != 0 || in_valid || result_q.size() != 0) && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
